// ===== rtl/core/blg_pkg.sv =====
// Shared types, constants and helpers for the Bresenham line generator.
// Used by blg_ctrl, blg_dp and bresenham_line_generator; depends on nothing.
package blg_pkg;

	// Largest line span in pixels and the counter width that follows from it
	localparam int MAX_DIM = 64;
	localparam int CNT_W   = $clog2(MAX_DIM);

	// Fixed field widths
	localparam int COORD_W = 6;
	localparam int LIM_W   = 7;
	localparam int ERR_W   = 9;
	localparam int E2_W    = 10;

	// Register file layout
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic REG_ROW_LIMIT = 1'b0;
	localparam logic REG_COL_LIMIT = 1'b1;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ERR
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic show_err;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;
		logic range_bad;
	} dp_stat_t;

	// Coordinate lies at or beyond the limit; limits of MAX_DIM and up admit everything
	function automatic logic coord_bad(input logic [COORD_W-1:0] coord,
			input logic [LIM_W-1:0] lim);
		logic bad;
		bad = (lim < LIM_W'(MAX_DIM)) && ({1'b0, coord} >= lim);
		return bad;
	endfunction

endpackage

// ===== rtl/core/blg_ctrl.sv =====
// Controller state machine of the Bresenham line generator.
// Depends on blg_pkg; drives blg_dp through dp_cmd_t and reads dp_stat_t.
module blg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  blg_pkg::dp_stat_t stat,
	output blg_pkg::dp_cmd_t  cmd
);

	blg_pkg::state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blg_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n      = state_q;
		in_stall     = 1'b1;
		out_valid    = 1'b0;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.show_err = 1'b0;
		unique case (state_q)
			blg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = stat.range_bad ? blg_pkg::ST_ERR : blg_pkg::ST_RUN;
				end
			end
			blg_pkg::ST_RUN: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (stat.last) begin
						state_n = blg_pkg::ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			blg_pkg::ST_ERR: begin
				out_valid    = 1'b1;
				cmd.show_err = 1'b1;
				if (!out_stall) begin
					state_n = blg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = blg_pkg::ST_IDLE;
			end
		endcase
	end

	// A stalled pixel keeps the walk in place
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == blg_pkg::ST_RUN && out_stall) |=> (state_q == blg_pkg::ST_RUN))
		else $error("walk left RUN while the pixel was stalled");

	// Only the last pixel ends the walk
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == blg_pkg::ST_RUN && !stat.last) |=> (state_q == blg_pkg::ST_RUN))
		else $error("walk ended before the last pixel");

endmodule

// ===== rtl/core/blg_dp.sv =====
// Datapath of the Bresenham line generator: range check, walk registers, error term.
// Depends on blg_pkg; commanded by blg_ctrl.
module blg_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  blg_pkg::dp_cmd_t                    cmd,
	output blg_pkg::dp_stat_t                   stat,
	input  logic [blg_pkg::LIM_W-1:0]           row_limit,
	input  logic [blg_pkg::LIM_W-1:0]           col_limit,
	input  logic [blg_pkg::COORD_W-1:0]         start_x,
	input  logic [blg_pkg::COORD_W-1:0]         start_y,
	input  logic [blg_pkg::COORD_W-1:0]         end_x,
	input  logic [blg_pkg::COORD_W-1:0]         end_y,
	output logic [blg_pkg::COORD_W-1:0]         pixel_x,
	output logic [blg_pkg::COORD_W-1:0]         pixel_y,
	output logic                                last_pixel,
	output logic                                range_error
);

	logic [blg_pkg::COORD_W-1:0]      x_q, y_q, xe_q, ye_q, dx_q;
	logic signed [blg_pkg::COORD_W:0] dy_q;
	logic                             sx_q, sy_q;
	logic signed [blg_pkg::ERR_W-1:0] err_q;
	logic [blg_pkg::CNT_W-1:0]        cnt_q;

	logic [blg_pkg::COORD_W-1:0]      adx, ady;
	logic signed [blg_pkg::COORD_W:0] dy_init;
	logic signed [blg_pkg::E2_W-1:0]  e2, dy_ext, dx_ext;
	logic signed [blg_pkg::ERR_W-1:0] err_dx, err_dy, err_n;
	logic                             xstep, ystep, at_end;

	// Endpoint range check on the incoming segment
	assign stat.range_bad = blg_pkg::coord_bad(start_x, row_limit)
		| blg_pkg::coord_bad(end_x, row_limit)
		| blg_pkg::coord_bad(start_y, col_limit)
		| blg_pkg::coord_bad(end_y, col_limit);

	// Segment deltas at load
	always_comb begin
		adx     = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
		ady     = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
		dy_init = (blg_pkg::COORD_W+1)'(0) - $signed({1'b0, ady});
	end

	// Step decision from the doubled error term
	always_comb begin
		e2     = {err_q, 1'b0};
		dy_ext = blg_pkg::E2_W'(dy_q);
		dx_ext = $signed({{(blg_pkg::E2_W-blg_pkg::COORD_W){1'b0}}, dx_q});
		xstep  = (e2 >= dy_ext);
		ystep  = (e2 <= dx_ext);
		err_dx = $signed({{(blg_pkg::ERR_W-blg_pkg::COORD_W){1'b0}}, dx_q});
		err_dy = blg_pkg::ERR_W'(dy_q);
		err_n  = err_q + (xstep ? err_dy : '0) + (ystep ? err_dx : '0);
		at_end = (x_q == xe_q) && (y_q == ye_q);
	end

	// Last pixel: endpoint reached, span exhausted, or a step would overrun
	assign stat.last = at_end
		|| (cnt_q == blg_pkg::CNT_W'(blg_pkg::MAX_DIM - 1))
		|| (xstep && (x_q == xe_q))
		|| (ystep && (y_q == ye_q));

	// Walk registers: load a segment, advance one pixel per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= start_x;
			y_q   <= start_y;
			xe_q  <= end_x;
			ye_q  <= end_y;
			dx_q  <= adx;
			dy_q  <= dy_init;
			sx_q  <= (start_x < end_x);
			sy_q  <= (start_y < end_y);
			err_q <= $signed({{(blg_pkg::ERR_W-blg_pkg::COORD_W){1'b0}}, adx})
				+ blg_pkg::ERR_W'(dy_init);
			cnt_q <= '0;
		end else if (cmd.step) begin
			if (xstep) begin
				x_q <= sx_q ? (x_q + 1'b1) : (x_q - 1'b1);
			end
			if (ystep) begin
				y_q <= sy_q ? (y_q + 1'b1) : (y_q - 1'b1);
			end
			err_q <= err_n;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Result fields; the error result carries zero coordinates
	assign pixel_x     = cmd.show_err ? '0 : x_q;
	assign pixel_y     = cmd.show_err ? '0 : y_q;
	assign last_pixel  = cmd.show_err | stat.last;
	assign range_error = cmd.show_err;

	// Every step moves at least one coordinate
	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (($past(x_q) != x_q) || ($past(y_q) != y_q)))
		else $error("step left the pixel in place");

endmodule

// ===== rtl/core/bresenham_line_generator.sv =====
// Top level of the Bresenham line generator: register port, controller, datapath.
// Depends on blg_pkg, blg_ctrl and blg_dp.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  segment   | in_valid / in_stall   | start_x, start_y, end_x, end_y
//  pixel     | out_valid / out_stall | pixel_x, pixel_y, last_pixel, range_error
//  registers | APB psel/penable      | row_limit @0x0, col_limit @0x4
//
// A segment is taken while idle, then one pixel transfers per cycle unless out_stall
// holds it: a line of n pixels (n = max(|dx|,|dy|)+1, at most 64) is walked by
// the single walk unit, stepping the error term once per pixel.
// An out-of-range segment gives a single error transfer.
// Reset returns the controller to idle and both limits to 64.
// out_stall holds the current pixel and freezes the walk; in_stall is high
// whenever a segment is in progress.
module bresenham_line_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [blg_pkg::ADDR_W-1:0]    paddr,
	input  logic [blg_pkg::DATA_W-1:0]    pwdata,
	output logic [blg_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [blg_pkg::COORD_W-1:0]   start_x,
	input  logic [blg_pkg::COORD_W-1:0]   start_y,
	input  logic [blg_pkg::COORD_W-1:0]   end_x,
	input  logic [blg_pkg::COORD_W-1:0]   end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [blg_pkg::COORD_W-1:0]   pixel_x,
	output logic [blg_pkg::COORD_W-1:0]   pixel_y,
	output logic                          last_pixel,
	output logic                          range_error
);

	logic [blg_pkg::LIM_W-1:0] row_limit_q, col_limit_q;
	logic                      reg_sel;
	blg_pkg::dp_cmd_t          cmd;
	blg_pkg::dp_stat_t         stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	// Limit registers, written on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_limit_q <= blg_pkg::LIMIT_RESET;
			col_limit_q <= blg_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				blg_pkg::REG_ROW_LIMIT: row_limit_q <= pwdata[blg_pkg::LIM_W-1:0];
				blg_pkg::REG_COL_LIMIT: col_limit_q <= pwdata[blg_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			blg_pkg::REG_ROW_LIMIT: prdata = blg_pkg::DATA_W'(row_limit_q);
			blg_pkg::REG_COL_LIMIT: prdata = blg_pkg::DATA_W'(col_limit_q);
			default:                prdata = '0;
		endcase
	end

	blg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	blg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.row_limit   (row_limit_q),
		.col_limit   (col_limit_q),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_pixel  (last_pixel),
		.range_error (range_error)
	);

	// An error result is a single, last transfer with zero coordinates
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (last_pixel && pixel_x == '0 && pixel_y == '0))
		else $error("error result is malformed");

	// An accepted segment always produces a result next cycle
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted segment produced no result");

endmodule

// ===== bench/tb.sv =====
// Testbench for bresenham_line_generator: drives segments and limit writes, checks every pixel.
// Depends on blg_pkg and the bresenham_line_generator RTL; self-contained otherwise.
module tb;
	import blg_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic               is_last;
		logic               bad;
	} pixel_t;

	// Traces each accepted segment into the pixels it should produce and checks arrivals
	class line_checker;
		logic [LIM_W-1:0] row_lim = LIMIT_RESET;
		logic [LIM_W-1:0] col_lim = LIMIT_RESET;
		pixel_t           due[$];
		int               errors = 0;

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task set_limit(logic idx, logic [LIM_W-1:0] value);
			if (idx == REG_ROW_LIMIT) begin
				row_lim = value;
			end else begin
				col_lim = value;
			end
		endtask

		// Walk the segment with the doubled-error rule, flag the final pixel
		task add_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
				logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
			int x, y, xe, ye, rl, cl, dx, dy, sx, sy, err, e2, n;
			pixel_t cur;
			rl = (row_lim < MAX_DIM) ? row_lim : MAX_DIM;
			cl = (col_lim < MAX_DIM) ? col_lim : MAX_DIM;
			x = x0;
			y = y0;
			xe = x1;
			ye = y1;
			if (x >= rl || xe >= rl || y >= cl || ye >= cl) begin
				cur = '{px: '0, py: '0, is_last: 1'b1, bad: 1'b1};
				due.push_back(cur);
				return;
			end
			dx = (xe > x) ? xe - x : x - xe;
			dy = (ye > y) ? y - ye : ye - y;
			sx = (x < xe) ? 1 : -1;
			sy = (y < ye) ? 1 : -1;
			err = dx + dy;
			n = 0;
			forever begin
				cur = '{px: COORD_W'(x), py: COORD_W'(y), is_last: 1'b0, bad: 1'b0};
				n++;
				if ((x == xe && y == ye) || n >= MAX_DIM) break;
				e2 = 2 * err;
				if (e2 >= dy) begin
					if (x == xe) break;
					err += dy;
					x += sx;
				end
				if (e2 <= dx) begin
					if (y == ye) break;
					err += dx;
					y += sy;
				end
				due.push_back(cur);
			end
			cur.is_last = 1'b1;
			due.push_back(cur);
		endtask

		task check_pixel(pixel_t got);
			pixel_t want;
			if (due.size() == 0) begin
				report($sformatf("pixel (%0d,%0d) with no segment pending", got.px, got.py));
				return;
			end
			want = due.pop_front();
			if (got.px !== want.px)
				report($sformatf("pixel_x %0d, want %0d", got.px, want.px));
			if (got.py !== want.py)
				report($sformatf("pixel_y %0d, want %0d", got.py, want.py));
			if (got.is_last !== want.is_last)
				report($sformatf("last_pixel %0b, want %0b", got.is_last, want.is_last));
			if (got.bad !== want.bad)
				report($sformatf("range_error %0b, want %0b", got.bad, want.bad));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic               out_valid;
	logic               out_stall;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic               last_pixel;
	logic               range_error;

	int idle_pct  = 0;
	int stall_pct = 0;

	line_checker sb = new();

	bresenham_line_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel),
		.range_error(range_error)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the pixel channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Note accepted segments and check each pixel transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.add_segment(start_x, start_y, end_x, end_y);
			if (out_valid && !out_stall)
				sb.check_pixel('{px: pixel_x, py: pixel_y, is_last: last_pixel,
						bad: range_error});
		end
	end

	function automatic int usable(logic [LIM_W-1:0] lim);
		return (lim < MAX_DIM) ? lim : MAX_DIM;
	endfunction

	// Offer one segment, idling first at random, and hold it until the transfer
	task automatic send_segment(int x0, int y0, int x1, int y1);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x  <= COORD_W'(x0);
		start_y  <= COORD_W'(y0);
		end_x    <= COORD_W'(x1);
		end_y    <= COORD_W'(y1);
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Mostly segments inside the current limits, the rest anywhere in the field range
	task automatic send_random();
		int lr, lc;
		lr = usable(sb.row_lim);
		lc = usable(sb.col_lim);
		if (lr > 0 && lc > 0 && $urandom_range(4) != 0) begin
			send_segment($urandom_range(lr - 1), $urandom_range(lc - 1),
					$urandom_range(lr - 1), $urandom_range(lc - 1));
		end else begin
			send_segment($urandom_range(63), $urandom_range(63),
					$urandom_range(63), $urandom_range(63));
		end
	endtask

	// Drop valid, wait for every outstanding pixel, then let the block go idle
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		// Let the monitor note a segment taken at the edge just passed
		@(posedge clk);
		waited = 0;
		while (sb.due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.due.size() != 0) begin
			sb.report($sformatf("%0d pixels never arrived", sb.due.size()));
			sb.due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge
	task automatic write_limit(logic idx, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= DATA_W'(LIM_W'(value));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_limit(idx, LIM_W'(value));
	endtask

	task automatic pick_limits();
		case ($urandom_range(3))
			0: begin
				write_limit(REG_ROW_LIMIT, 64);
				write_limit(REG_COL_LIMIT, 64);
			end
			1: begin
				write_limit(REG_ROW_LIMIT, $urandom_range(64, 1));
				write_limit(REG_COL_LIMIT, $urandom_range(64, 1));
			end
			2: begin
				write_limit(REG_ROW_LIMIT, $urandom_range(127));
				write_limit(REG_COL_LIMIT, $urandom_range(127));
			end
			default: begin
				write_limit(REG_ROW_LIMIT, 127);
				write_limit(REG_COL_LIMIT, $urandom_range(64, 1));
			end
		endcase
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		start_x  = '0;
		start_y  = '0;
		end_x    = '0;
		end_y    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners, diagonals, axis lines and three of the eight octants at reset limits
		send_segment(0, 0, 0, 0);
		send_segment(63, 63, 63, 63);
		send_segment(0, 0, 63, 63);
		send_segment(63, 63, 0, 0);
		send_segment(0, 63, 63, 0);
		send_segment(63, 0, 0, 63);
		send_segment(0, 0, 63, 0);
		send_segment(0, 0, 0, 63);
		send_segment(10, 5, 3, 30);
		send_segment(40, 20, 2, 25);
		send_segment(7, 50, 60, 45);
		send_segment(21, 42, 42, 21);

		// Endpoints on and past the limits
		settle();
		write_limit(REG_ROW_LIMIT, 10);
		write_limit(REG_COL_LIMIT, 20);
		send_segment(9, 19, 0, 0);
		send_segment(10, 0, 0, 0);
		send_segment(0, 0, 0, 20);
		send_segment(0, 0, 12, 3);

		// Zero limit rejects everything
		settle();
		write_limit(REG_ROW_LIMIT, 0);
		write_limit(REG_COL_LIMIT, 64);
		send_segment(0, 0, 0, 0);

		// Limits above the maximum act as the maximum; a limit of one admits only zero
		settle();
		write_limit(REG_ROW_LIMIT, 127);
		write_limit(REG_COL_LIMIT, 1);
		send_segment(63, 0, 0, 0);
		send_segment(0, 1, 0, 0);
		send_segment(5, 0, 60, 0);

		settle();
		write_limit(REG_ROW_LIMIT, 64);
		write_limit(REG_COL_LIMIT, 100);
		send_segment(3, 63, 50, 10);

		// Random segments under each idling and stalling pattern, new limits twice per pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int half = 0; half < 2; half++) begin
				settle();
				pick_limits();
				repeat (14) send_random();
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
